FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the vertex cover block.
// Depends on nothing; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GVC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GVC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gvc_pkg.sv
// Types, codes and helper functions of the greedy vertex cover block.
// Depends on nothing; the interfaces, top level, checker and bench use it.
package gvc_pkg;

	localparam int OPCODE_W     = 2;
	localparam int VERTEX_W     = 5;
	localparam int COUNT_W      = VERTEX_W + 1;
	localparam int VERTEX_LIMIT = 32;
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(32);

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR    = 2'd0,
		OP_ADD_EDGE = 2'd1,
		OP_RUN      = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// Lowest set bit of a 32-bit word; zero for an empty word.
	function automatic logic [VERTEX_W-1:0] ffs32(input logic [VERTEX_LIMIT-1:0] x);
		logic [VERTEX_W-1:0] r;
		r = '0;
		for (int k = VERTEX_LIMIT - 1; k >= 0; k--) begin
			if (x[k]) begin
				r = VERTEX_W'(k);
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/gvc_if.sv
// Valid/ready channel interfaces: command in, result out, configuration write.
// Depends on gvc_pkg for field widths.
interface gvc_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [gvc_pkg::OPCODE_W-1:0]     opcode;
	logic [gvc_pkg::VERTEX_W-1:0]     first_vertex;
	logic [gvc_pkg::VERTEX_W-1:0]     second_vertex;

	modport source (output valid, output opcode, output first_vertex,
		output second_vertex, input ready);
	modport sink (input valid, input opcode, input first_vertex,
		input second_vertex, output ready);
endinterface

interface gvc_res_if;
	logic                             valid;
	logic                             ready;
	logic [gvc_pkg::VERTEX_W-1:0]     cover_vertex;
	logic                             has_vertex;
	logic                             last;

	modport source (output valid, output cover_vertex, output has_vertex,
		output last, input ready);
	modport sink (input valid, input cover_vertex, input has_vertex,
		input last, output ready);
endinterface

interface gvc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [gvc_pkg::COUNT_W-1:0]      vertex_count;

	modport source (output valid, output vertex_count, input ready);
	modport sink (input valid, input vertex_count, output ready);
endinterface

FILE: rtl/gvc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module gvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/greedy_vertex_cover.sv
// Top level of the greedy vertex cover block: control, scan and result stage.
// Depends on gvc_pkg, gvc_if and gvc_ram.
//
// Usage:
//  - cmd carries one command per transaction: clear graph, add edge or run.
//    cfg writes vertex_count (vertices in use); write it only while idle.
//  - Clear drops the row valid bits at once, with no memory sweep.
//  - Add edge reads row A, then writes row A and reads row B, then writes
//    row B. An edge with an endpoint at or above the count in use is
//    dropped and the block stays idle.
//  - Run scans rows 0..n-1 one per cycle through the adjacency RAM read port
//    (find-first-set on each row), then emits one covered vertex per cycle
//    while res is not stalled, in ascending order, lowest remaining mark
//    first; last flags the final one. An empty cover gives a single
//    transaction with has_vertex low and last high.
//  - cmd.ready is high only while idle. A finished result sits in the
//    output register, so the next command is taken while it waits.
//  - A stall on res holds the output register and the emit sequence.
//  - Reset empties the graph, sets vertex_count to 32, drops res.valid.
module greedy_vertex_cover #(
	parameter int MAX_VERTICES = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	gvc_cmd_if.sink   cmd,
	gvc_cfg_if.sink   cfg,
	gvc_res_if.source res
);

	import gvc_pkg::*;

	localparam int NV = (MAX_VERTICES < VERTEX_LIMIT) ? MAX_VERTICES : VERTEX_LIMIT;
	localparam int AW = $clog2(NV);
	localparam logic [COUNT_W-1:0] NV_CNT = COUNT_W'(NV);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] vcount_q;
	logic [COUNT_W-1:0] n_act;
	logic [NV-1:0]      valid_q;
	logic [NV-1:0]      marks_q;
	logic [NV-1:0]      rem_q;
	logic [NV-1:0]      fwd_q;
	logic [AW-1:0]      a_q, b_q, idx_q;

	logic [NV-1:0]      mask;
	logic [NV-1:0]      row_a, row_b, row_s;
	logic [NV-1:0]      wdata_a, wdata_b;
	logic [NV-1:0]      cand, marks_d, rem_after;
	logic [VERTEX_W-1:0] j_full, e_full;
	logic [AW-1:0]      j_idx, e_idx;
	logic               take, scan_last, edge_ok, cmd_fire, slot_free, clear_all;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [NV-1:0]      ram_wdata, ram_rdata;

	logic               out_load, out_has, out_last;
	logic               out_valid_q, out_has_q, out_last_q;
	logic [VERTEX_W-1:0] out_vertex_q;

	gvc_ram #(
		.WIDTH (NV),
		.DEPTH (NV)
	) u_adj_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Vertices in use: configured count, capped at the matrix size.
	assign n_act = (vcount_q > NV_CNT) ? NV_CNT : vcount_q;

	always_comb begin
		for (int w = 0; w < NV; w++) begin
			mask[w] = (COUNT_W'(w) < n_act);
		end
	end

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign clear_all = cmd_fire && (cmd.opcode == OP_CLEAR);
	assign edge_ok   = ({1'b0, cmd.first_vertex} < n_act) &&
		({1'b0, cmd.second_vertex} < n_act);

	// Rows whose valid bit is low read as empty. Row B forwards row A's
	// fresh write on a self loop, since that read overlapped the write.
	assign row_a   = valid_q[a_q] ? ram_rdata : '0;
	assign row_b   = (a_q == b_q) ? fwd_q : (valid_q[b_q] ? ram_rdata : '0);
	assign row_s   = valid_q[idx_q] ? ram_rdata : '0;
	assign wdata_a = row_a | (NV'(1) << b_q);
	assign wdata_b = row_b | (NV'(1) << a_q);

	// Scan step: lowest unmarked neighbour of an unmarked vertex.
	assign cand      = row_s & mask & ~marks_q;
	assign j_full    = ffs32(VERTEX_LIMIT'(cand));
	assign j_idx     = j_full[AW-1:0];
	assign take      = !marks_q[idx_q] && (cand != '0);
	assign marks_d   = take ? (marks_q | (NV'(1) << idx_q) | (NV'(1) << j_idx)) : marks_q;
	assign scan_last = (COUNT_W'(idx_q) == (n_act - COUNT_W'(1)));

	// Emit step: lowest remaining mark.
	assign e_full    = ffs32(VERTEX_LIMIT'(rem_q));
	assign e_idx     = e_full[AW-1:0];
	assign rem_after = rem_q & ~(NV'(1) << e_idx);
	assign slot_free = !out_valid_q || res.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					case (cmd.opcode)
						OP_ADD_EDGE: begin
							if (edge_ok) begin
								state_d = ST_EDGE_A;
							end
						end
						OP_RUN: begin
							state_d = (n_act == '0) ? ST_EMIT : ST_SCAN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_EDGE_A: begin
				state_d = ST_EDGE_B;
			end
			ST_EDGE_B: begin
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free && (rem_after == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory and result stage controls.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = a_q;
		ram_wdata = wdata_a;
		ram_raddr = idx_q + AW'(1);
		out_load  = 1'b0;
		out_has   = (rem_q != '0);
		out_last  = (rem_after == '0);
		case (state_q)
			ST_IDLE: begin
				ram_raddr = (cmd.opcode == OP_RUN) ? '0 : cmd.first_vertex[AW-1:0];
			end
			ST_EDGE_A: begin
				ram_we    = 1'b1;
				ram_waddr = a_q;
				ram_wdata = wdata_a;
				ram_raddr = b_q;
			end
			ST_EDGE_B: begin
				ram_we    = 1'b1;
				ram_waddr = b_q;
				ram_wdata = wdata_b;
			end
			ST_SCAN: begin
				ram_raddr = idx_q + AW'(1);
			end
			ST_EMIT: begin
				out_load = slot_free;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vcount_q    <= COUNT_RESET;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				vcount_q <= cfg.vertex_count;
			end
			if (clear_all) begin
				valid_q <= '0;
			end else if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			a_q     <= cmd.first_vertex[AW-1:0];
			b_q     <= cmd.second_vertex[AW-1:0];
			idx_q   <= '0;
			marks_q <= '0;
			rem_q   <= '0;
		end
		if (state_q == ST_EDGE_A) begin
			fwd_q <= wdata_a;
		end
		if (state_q == ST_SCAN) begin
			marks_q <= marks_d;
			idx_q   <= idx_q + AW'(1);
			if (scan_last) begin
				rem_q <= marks_d;
			end
		end
		if (out_load) begin
			rem_q        <= rem_after;
			out_vertex_q <= e_full;
			out_has_q    <= out_has;
			out_last_q   <= out_last;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.cover_vertex = out_vertex_q;
	assign res.has_vertex   = out_has_q;
	assign res.last         = out_last_q;

endmodule

FILE: rtl/gvc_checker.sv
// Port-level checker for greedy_vertex_cover and the bind that attaches it.
// Depends on gvc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gvc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic [gvc_pkg::OPCODE_W-1:0] cmd_opcode,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [gvc_pkg::VERTEX_W-1:0] res_cover_vertex,
	input logic                         res_has_vertex,
	input logic                         res_last
);

	import gvc_pkg::*;

	// Hold a stalled result.
	`GVC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_cover_vertex) && $stable(res_has_vertex) && $stable(res_last), "stalled result changed")

	// An empty cover is always the only and final result.
	`GVC_ASSERT_SAME(a_empty_last, clk, arst_n, res_valid && !res_has_vertex, res_last, "empty result without last")

	// More results pending: no new command may be taken.
	`GVC_ASSERT_SAME(a_busy_emit, clk, arst_n, res_valid && !res_last, !cmd_ready, "command taken mid run")

	// A run keeps the command side closed for at least its next cycle.
	`GVC_ASSERT_NEXT(a_run_busy, clk, arst_n, cmd_valid && cmd_ready && (cmd_opcode == OP_RUN), !cmd_ready, "ready right after run")

endmodule

bind greedy_vertex_cover gvc_checker u_gvc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.cmd_opcode       (cmd.opcode),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_cover_vertex (res.cover_vertex),
	.res_has_vertex   (res.has_vertex),
	.res_last         (res.last)
);

FILE: bench/greedy_vertex_cover_test.sv
// Self-checking bench for greedy_vertex_cover: directed and random command streams,
// an in-bench cover predictor and an in-order result scoreboard.
// Depends on gvc_pkg, the channel interfaces in gvc_if.sv and the block's RTL.
module greedy_vertex_cover_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gvc_pkg::*;

	// The package names only the three live opcodes; the fourth code must be ignored.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

	localparam int CLK_HALF      = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int RANDOM_ITEMS  = 100;
	// An add edge occupies the block with no result to show for it.
	localparam int SETTLE_CYCLES = 6;
	// Once this few steps are left, neither side draws new random pauses.
	localparam int TAIL_STEPS    = 30;
	// Sized for the longest run: the full scan before the first result.
	localparam int DRAIN_CYCLES  = 40;
	localparam int STALL_LIMIT   = 2000;

	typedef enum logic [1:0] {
		STEP_CMD,
		STEP_CFG,
		STEP_DRAIN
	} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		logic [OPCODE_W-1:0]   opcode;
		logic [VERTEX_W-1:0]   first_vertex;
		logic [VERTEX_W-1:0]   second_vertex;
		logic [COUNT_W-1:0]    vertex_count;
	} plan_step_t;

	typedef struct packed {
		logic [VERTEX_W-1:0]   cover_vertex;
		logic                  has_vertex;
		logic                  last;
	} cover_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gvc_cmd_if cmd_ch ();
	gvc_cfg_if cfg_ch ();
	gvc_res_if res_ch ();

	greedy_vertex_cover #(
		.MAX_VERTICES(VERTEX_LIMIT)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	// Stimulus plan, filled up front and consumed by the driver.
	plan_step_t pending_steps[$];

	// Predictor state: adjacency matrix, vertex count in force, covers still owed.
	logic [VERTEX_LIMIT-1:0] graph_rows [VERTEX_LIMIT];
	logic [COUNT_W-1:0]      model_count;
	cover_result_t           cover_expect[$];

	logic results_pending;
	logic tail_phase;

	int mismatches = 0;
	int cmds_seen = 0;
	int runs_seen = 0;
	int results_seen = 0;
	int cfg_writes = 0;

	// Driver, receiver and watchdog bookkeeping.
	int send_gap;
	int send_mode;
	int quiet_cycles;
	int stall_left;
	int recv_mode;
	int idle_cycles = 0;
	logic hold_cmd, hold_cfg, cmd_valid_next, cfg_valid_next;
	plan_step_t next_step;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------

	// Count and print every mismatch.
	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("%0t ns mismatch: %s", $time, msg);
	endtask

	// Idle probability in percent for a pacing mode: none, light, heavy.
	function automatic int mode_percent(input int mode);
		case (mode)
			0: return 0;
			1: return 10;
			default: return 40;
		endcase
	endfunction

	task automatic add_cmd(input logic [OPCODE_W-1:0] op, input int a, input int b);
		plan_step_t s;
		s = '{kind: STEP_CMD, opcode: op, first_vertex: VERTEX_W'(a),
			second_vertex: VERTEX_W'(b), vertex_count: '0};
		pending_steps.push_back(s);
	endtask

	task automatic add_cfg(input int count);
		plan_step_t s;
		s = '{kind: STEP_CFG, opcode: OP_CLEAR, first_vertex: '0,
			second_vertex: '0, vertex_count: COUNT_W'(count)};
		pending_steps.push_back(s);
	endtask

	// Hold the sender until every owed result has arrived and the block has settled.
	task automatic add_drain();
		plan_step_t s;
		s = '{kind: STEP_DRAIN, opcode: OP_CLEAR, first_vertex: '0,
			second_vertex: '0, vertex_count: '0};
		pending_steps.push_back(s);
	endtask

	// Apply one accepted command to the predictor and queue the cover it owes.
	task automatic model_command(input logic [OPCODE_W-1:0] op,
			input logic [VERTEX_W-1:0] a, input logic [VERTEX_W-1:0] b);
		int n;
		int emitted;
		logic [VERTEX_LIMIT-1:0] in_use;
		logic [VERTEX_LIMIT-1:0] marks;
		logic [VERTEX_LIMIT-1:0] cand;
		cover_result_t item;
		// Counts above the matrix size saturate; zero leaves no vertex in use.
		n = (model_count > VERTEX_LIMIT) ? VERTEX_LIMIT : int'(model_count);
		in_use = VERTEX_LIMIT'((64'd1 << n) - 64'd1);
		case (op)
			OP_CLEAR: begin
				for (int r = 0; r < VERTEX_LIMIT; r++) graph_rows[r] = '0;
			end
			OP_ADD_EDGE: begin
				// Drop edges that reach past the count in force right now.
				if (a < n && b < n) begin
					graph_rows[a][b] = 1'b1;
					graph_rows[b][a] = 1'b1;
				end
			end
			OP_RUN: begin
				runs_seen++;
				marks = '0;
				for (int i = 0; i < n; i++) begin
					if (!marks[i]) begin
						// Stale bits past the count are masked off; a self loop
						// makes the vertex its own lowest neighbour.
						cand = graph_rows[i] & in_use & ~marks;
						if (cand != '0) begin
							marks[i] = 1'b1;
							for (int k = 0; k < VERTEX_LIMIT; k++) begin
								if (cand[k]) begin
									marks[k] = 1'b1;
									break;
								end
							end
						end
					end
				end
				emitted = 0;
				for (int i = 0; i < n; i++) begin
					if (marks[i]) begin
						item = '{cover_vertex: VERTEX_W'(i), has_vertex: 1'b1, last: 1'b0};
						cover_expect.push_back(item);
						emitted++;
					end
				end
				if (emitted == 0) begin
					item = '{cover_vertex: '0, has_vertex: 1'b0, last: 1'b1};
					cover_expect.push_back(item);
				end else begin
					cover_expect[cover_expect.size() - 1].last = 1'b1;
				end
			end
			default: begin
				// Unused opcode: no state change, no result.
			end
		endcase
	endtask

	// Compare one accepted result against the oldest owed one, field by field.
	task automatic check_result();
		cover_result_t want;
		results_seen++;
		if (cover_expect.size() == 0) begin
			log_mismatch($sformatf("unexpected result vertex %0d has_vertex %0b last %0b",
				res_ch.cover_vertex, res_ch.has_vertex, res_ch.last));
		end else begin
			want = cover_expect.pop_front();
			if (res_ch.cover_vertex !== want.cover_vertex)
				log_mismatch($sformatf("cover_vertex %0d, expected %0d",
					res_ch.cover_vertex, want.cover_vertex));
			if (res_ch.has_vertex !== want.has_vertex)
				log_mismatch($sformatf("has_vertex %0b, expected %0b (vertex %0d)",
					res_ch.has_vertex, want.has_vertex, want.cover_vertex));
			if (res_ch.last !== want.last)
				log_mismatch($sformatf("last %0b, expected %0b (vertex %0d)",
					res_ch.last, want.last, want.cover_vertex));
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: walk the plan, one transaction at a time on cmd or cfg
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid         <= 1'b0;
			cmd_ch.opcode        <= OP_CLEAR;
			cmd_ch.first_vertex  <= '0;
			cmd_ch.second_vertex <= '0;
			cfg_ch.valid         <= 1'b0;
			cfg_ch.vertex_count  <= COUNT_RESET;
			tail_phase           <= 1'b0;
			send_gap = 0;
			send_mode = 0;
			quiet_cycles = 0;
		end else begin
			hold_cmd = cmd_ch.valid && !cmd_ch.ready;
			hold_cfg = cfg_ch.valid && !cfg_ch.ready;
			// Count cycles with nothing in flight: no offered transaction, no result owed.
			if (cmd_ch.valid || cfg_ch.valid || results_pending)
				quiet_cycles = 0;
			else
				quiet_cycles++;

			// A stalled transaction keeps its valid and payload; touch nothing.
			if (!hold_cmd && !hold_cfg) begin
				cmd_valid_next = 1'b0;
				cfg_valid_next = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_steps.size() != 0) begin
					next_step = pending_steps[0];
					case (next_step.kind)
						STEP_CMD: begin
							void'(pending_steps.pop_front());
							cmd_ch.opcode        <= next_step.opcode;
							cmd_ch.first_vertex  <= next_step.first_vertex;
							cmd_ch.second_vertex <= next_step.second_vertex;
							cmd_valid_next = 1'b1;
							// Reshuffle the pacing now and then so quiet and busy
							// stretches both occur.
							if ($urandom_range(0, 15) == 0)
								send_mode = $urandom_range(0, 2);
							if (!tail_phase && $urandom_range(0, 99) < mode_percent(send_mode))
								send_gap = $urandom_range(1, 17);
						end
						STEP_CFG: begin
							// Write the register only once the block has gone idle.
							if (quiet_cycles >= SETTLE_CYCLES) begin
								void'(pending_steps.pop_front());
								cfg_ch.vertex_count <= next_step.vertex_count;
								cfg_valid_next = 1'b1;
							end
						end
						default: begin
							if (quiet_cycles >= SETTLE_CYCLES)
								void'(pending_steps.pop_front());
						end
					endcase
				end
				cmd_ch.valid <= cmd_valid_next;
				cfg_ch.valid <= cfg_valid_next;
			end
			tail_phase <= (pending_steps.size() <= TAIL_STEPS);
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random backpressure on res, in bursts of stalled cycles
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			stall_left = 0;
			recv_mode = 1;
		end else begin
			if ($urandom_range(0, 63) == 0)
				recv_mode = $urandom_range(0, 2);
			if (stall_left > 0) begin
				res_ch.ready <= 1'b0;
				stall_left--;
			end else if (!tail_phase && $urandom_range(0, 99) < mode_percent(recv_mode)) begin
				res_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 16);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: watch all three channels, predict on cmd, check on res
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < VERTEX_LIMIT; r++) graph_rows[r] = '0;
			model_count = COUNT_RESET;
			cover_expect.delete();
			results_pending <= 1'b0;
		end else begin
			// Results first: a run taken this cycle cannot have produced one yet.
			if (res_ch.valid && res_ch.ready)
				check_result();
			if (cfg_ch.valid && cfg_ch.ready) begin
				model_count = cfg_ch.vertex_count;
				cfg_writes++;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmds_seen++;
				model_command(cmd_ch.opcode, cmd_ch.first_vertex, cmd_ch.second_vertex);
			end
			results_pending <= (cover_expect.size() != 0);
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: abort when no transaction moves on any channel for too long
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
				|| (res_ch.valid && res_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Plan, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		int cmd_total;
		int span;
		int cfg_val;
		int edges;
		int a;
		int b;

		// Directed part, starting from the reset count of 32.
		add_cmd(OP_RUN, 31, 31);            // empty graph gives the empty-cover result
		add_cmd(OP_ADD_EDGE, 0, 31);        // extreme endpoints
		add_cmd(OP_ADD_EDGE, 5, 5);         // self loop
		add_cmd(OP_ADD_EDGE, 2, 3);
		add_cmd(OP_ADD_EDGE, 3, 4);
		add_cmd(OP_UNUSED, 7, 9);           // must change nothing
		add_cmd(OP_RUN, 0, 0);
		add_cmd(OP_CLEAR, 31, 0);
		add_cmd(OP_RUN, 0, 31);             // cleared graph is empty again
		add_cmd(OP_ADD_EDGE, 2, 20);        // becomes a stale bit once the count drops
		add_cmd(OP_ADD_EDGE, 6, 7);
		add_drain();
		add_cfg(8);
		add_cmd(OP_RUN, 0, 0);
		add_cmd(OP_ADD_EDGE, 1, 9);         // endpoint past the count: dropped
		add_cmd(OP_ADD_EDGE, 8, 0);
		add_cmd(OP_RUN, 0, 0);
		add_drain();
		add_cfg(1);                         // smallest real graph
		add_cmd(OP_ADD_EDGE, 0, 0);
		add_cmd(OP_RUN, 0, 0);
		add_drain();
		add_cfg(0);                         // nothing in use: empty cover
		add_cmd(OP_ADD_EDGE, 0, 0);
		add_cmd(OP_RUN, 0, 0);
		add_drain();
		add_cfg(63);                        // saturates to the full matrix
		add_cmd(OP_RUN, 31, 31);

		// Random part: mostly clear, load a few edges, run; small graphs dominate.
		span = VERTEX_LIMIT;
		cmd_total = 0;
		while (cmd_total < RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				add_drain();
				case ($urandom_range(0, 11))
					0: cfg_val = VERTEX_LIMIT;
					1: cfg_val = 1;
					2: cfg_val = $urandom_range(VERTEX_LIMIT + 1, 63);
					3: cfg_val = 0;
					4, 5: cfg_val = $urandom_range(9, VERTEX_LIMIT - 1);
					default: cfg_val = $urandom_range(2, 8);
				endcase
				add_cfg(cfg_val);
				span = (cfg_val > VERTEX_LIMIT) ? VERTEX_LIMIT : (cfg_val < 1 ? 1 : cfg_val);
			end
			if ($urandom_range(0, 4) != 0) begin
				add_cmd(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31));
				cmd_total++;
			end
			edges = $urandom_range(1, (span < 4) ? 3 : 10);
			repeat (edges) begin
				if ($urandom_range(0, 9) < 8) begin
					a = $urandom_range(0, span - 1);
					b = ($urandom_range(0, 7) == 0) ? a : $urandom_range(0, span - 1);
				end else begin
					a = $urandom_range(0, 31);
					b = $urandom_range(0, 31);
				end
				add_cmd(OP_ADD_EDGE, a, b);
				cmd_total++;
				// Sprinkle noise: unused opcodes and runs in mid-load.
				if ($urandom_range(0, 11) == 0)
					add_cmd(OP_UNUSED, $urandom_range(0, 31), $urandom_range(0, 31));
				if ($urandom_range(0, 15) == 0) begin
					add_cmd(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31));
					cmd_total++;
				end
			end
			add_cmd(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31));
			cmd_total++;
			// Back-to-back runs on the same graph.
			if ($urandom_range(0, 4) == 0) begin
				add_cmd(OP_RUN, $urandom_range(0, 31), $urandom_range(0, 31));
				cmd_total++;
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the plan to empty and every owed result to land.
		do begin
			@(negedge clk);
		end while (pending_steps.size() != 0 || cmd_ch.valid || cfg_ch.valid
			|| results_pending);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (cover_expect.size() != 0)
			log_mismatch($sformatf("%0d expected results never arrived", cover_expect.size()));

		$display("Ran %0d commands (%0d cover runs) over %0d vertex_count settings;",
			cmds_seen, runs_seen, cfg_writes);
		$display("checked %0d cover results, %0d mismatches.", results_seen, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl
rtl/gvc_pkg.sv
rtl/gvc_if.sv
rtl/gvc_ram.sv
rtl/greedy_vertex_cover.sv
rtl/gvc_checker.sv
bench/greedy_vertex_cover_test.sv
